// File: rtl/apd_pkg.sv
// apd_pkg: shared types, constants and the DID/SDID type lookup for the
// ancillary packet deframer. Used by the top level and its checker.
// No dependencies.
package apd_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HUNT,
        PH_HEAD,
        PH_BODY
    } t_phase;

    // result kind codes
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_WORD   = 1'b1;

    localparam logic [4:0]  TYPE_UNKNOWN  = 5'd22;
    localparam logic [7:0]  SYNC_MASK     = 8'hFC;
    localparam logic [15:0] HUNT_MIN_LEFT = 16'd9;
    localparam logic [11:0] HDR_BASE_BITS = 12'd70;
    localparam logic [11:0] ROUND_BITS    = 12'd7;
    localparam logic [8:0]  HDR_BYTES     = 9'd8;
    localparam logic [2:0]  HDR_LAST_POS  = 3'd7;
    localparam logic [4:0]  WORD_BITS     = 5'd10;
    localparam logic [4:0]  BYTE_BITS     = 5'd8;
    localparam logic [4:0]  FIRST_HELD    = 5'd4;

    typedef struct packed {
        logic        kind;
        logic [10:0] line_number;
        logic [7:0]  did;
        logic [7:0]  sdid;
        logic [7:0]  data_count;
        logic [4:0]  data_type;
        logic [7:0]  data_word;
        logic [7:0]  word_index;
        logic        last;
    } t_result;

    function automatic logic [4:0] lookup_type(input logic [7:0] did, input logic [7:0] sdid);
        logic [4:0] kind_code;
        kind_code = TYPE_UNKNOWN;
        case ({did, sdid})
            16'h4105: kind_code = 5'd3;
            16'h4107: kind_code = 5'd5;
            16'h4108: kind_code = 5'd13;
            16'h410c: kind_code = 5'd20;
            16'h4302, 16'h4303: kind_code = 5'd4;
            16'h4501, 16'h4502, 16'h4503, 16'h4504, 16'h4505,
            16'h4506, 16'h4507, 16'h4508, 16'h4509: kind_code = 5'd7;
            16'h5fdc, 16'h5fde, 16'h5fdf: kind_code = 5'd18;
            16'h5ffe: kind_code = 5'd17;
            16'h6060: kind_code = 5'd6;
            16'h6101: kind_code = 5'd2;
            16'h6102: kind_code = 5'd0;
            16'h6201: kind_code = 5'd15;
            default: kind_code = TYPE_UNKNOWN;
        endcase
        return kind_code;
    endfunction

endpackage

// File: rtl/apd_stream_if.sv
// apd_stream_if: valid/ready channels of the ancillary packet deframer,
// one for payload bytes in and one for parsed results out.
// No dependencies.
interface apd_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        pes_start;
    logic [15:0] pes_size;

    modport source (output valid, output data_byte, output pes_start, output pes_size,
                    input ready);
    modport sink   (input valid, input data_byte, input pes_start, input pes_size,
                    output ready);
endinterface

interface apd_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [10:0] line_number;
    logic [7:0]  did;
    logic [7:0]  sdid;
    logic [7:0]  data_count;
    logic [4:0]  data_type;
    logic [7:0]  data_word;
    logic [7:0]  word_index;
    logic        last;

    modport source (output valid, output kind, output line_number, output did,
                    output sdid, output data_count, output data_type, output data_word,
                    output word_index, output last, input ready);
    modport sink   (input valid, input kind, input line_number, input did,
                    input sdid, input data_count, input data_type, input data_word,
                    input word_index, input last, output ready);
endinterface

// File: rtl/anc_packet_deframer.sv
// Ancillary packet deframer: takes one PES payload byte per cycle while ready and gives
// a header request per ancillary packet that fits in the PES, followed by one request per
// user data word. Every byte is handled in the cycle it is accepted, so the block sustains
// one byte per clock while ready; a result is registered and appears on the output in the
// cycle after the byte that causes it. The input is ready whenever the output register is
// empty or being taken, so a stalled sink stops the input only while a result waits.
// No clearing pass after reset. Depends on apd_pkg and the interfaces in apd_stream_if.sv.
module anc_packet_deframer (
    input  logic     i_clk,
    input  logic     i_rst_n,
    apd_in_if.sink   i_in,
    apd_out_if.source o_out
);
    import apd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_pes_left, n_pes_left;
    logic [7:0]  r_hdr [0:7];
    logic [2:0]  r_pos, n_pos;
    logic [8:0]  r_pkt_left, n_pkt_left;
    logic [7:0]  r_word_cnt, n_word_cnt;
    logic [15:0] r_bit_buf, n_bit_buf;
    logic [4:0]  r_bits_held, n_bits_held;
    logic        r_out_valid;
    t_result     r_out, n_res;
    logic        n_res_valid;

    logic        accept;
    logic        start;
    t_phase      eff_phase;
    logic [15:0] eff_left;
    logic [2:0]  eff_pos;
    logic [8:0]  eff_pkt;
    logic [7:0]  eff_wc;
    logic [15:0] eff_buf;
    logic [4:0]  eff_held;
    logic        have_byte;
    logic        sync_hit;
    logic        head_done;
    logic [7:0]  live_dc;
    logic [7:0]  stored_dc;
    logic [11:0] need_bits;
    logic [8:0]  need_bytes;
    logic        too_long;
    logic [8:0]  pkt_dec;
    logic [10:0] hdr_line;
    logic [7:0]  hdr_did;
    logic [7:0]  hdr_sdid;
    logic [4:0]  hdr_type;
    logic        word_room;
    logic [4:0]  held_sum;
    logic        emit;
    logic [4:0]  word_shift;
    logic [4:0]  held_next;
    logic [15:0] acc;
    logic [7:0]  word_val;
    logic        hdr_we;
    logic [2:0]  hdr_idx;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign start      = i_in.pes_start;

    // a new payload restarts the parse on this very byte
    assign eff_phase = start ? PH_HUNT : r_phase;
    assign eff_left  = start ? i_in.pes_size : r_pes_left;
    assign eff_pos   = start ? 3'd0 : r_pos;
    assign eff_pkt   = start ? 9'd0 : r_pkt_left;
    assign eff_wc    = start ? 8'd0 : r_word_cnt;
    assign eff_buf   = start ? 16'd0 : r_bit_buf;
    assign eff_held  = start ? 5'd0 : r_bits_held;

    assign have_byte = (eff_left != 16'd0);
    assign sync_hit  = ((i_in.data_byte & SYNC_MASK) == 8'd0);
    assign head_done = (eff_pos == HDR_LAST_POS);

    assign live_dc   = {r_hdr[6][3:0], i_in.data_byte[7:4]};
    assign stored_dc = {r_hdr[6][3:0], r_hdr[7][7:4]};

    // (70 + 10*dc + 7) / 8
    assign need_bits  = HDR_BASE_BITS + {1'b0, live_dc, 3'b000} + {3'b000, live_dc, 1'b0}
                      + ROUND_BITS;
    assign need_bytes = need_bits[11:3];
    assign too_long   = (({1'b0, eff_left} + 17'd7) < {8'd0, need_bytes});
    assign pkt_dec    = (eff_pkt != 9'd0) ? (eff_pkt - 9'd1) : 9'd0;

    assign hdr_line = {r_hdr[0][0], r_hdr[1], r_hdr[2][7:6]};
    assign hdr_did  = r_hdr[4];
    assign hdr_sdid = {r_hdr[5][5:0], r_hdr[6][7:6]};
    assign hdr_type = lookup_type(hdr_did, hdr_sdid);

    // 10-bit word unpacking; at most 8 bits are ever held between bytes
    assign word_room  = (eff_wc < stored_dc);
    assign held_sum   = eff_held + BYTE_BITS;
    assign emit       = (held_sum >= WORD_BITS);
    assign word_shift = held_sum - WORD_BITS;
    assign held_next  = emit ? word_shift : held_sum;
    assign acc        = {eff_buf[7:0], i_in.data_byte};
    assign word_val   = 8'(acc >> word_shift);

    // next state
    always_comb begin
        n_phase = eff_phase;
        if (!have_byte) begin
            n_phase = PH_IDLE;
        end else begin
            case (eff_phase)
                PH_IDLE: n_phase = PH_IDLE;
                PH_HUNT: begin
                    if (eff_left < HUNT_MIN_LEFT) begin
                        n_phase = PH_IDLE;
                    end else if (sync_hit) begin
                        n_phase = PH_HEAD;
                    end
                end
                PH_HEAD: begin
                    if (head_done) begin
                        n_phase = too_long ? PH_IDLE : PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (pkt_dec == 9'd0) begin
                        n_phase = PH_HUNT;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // datapath and results
    always_comb begin
        n_pes_left  = have_byte ? (eff_left - 16'd1) : eff_left;
        n_pos       = eff_pos;
        n_pkt_left  = eff_pkt;
        n_word_cnt  = eff_wc;
        n_bit_buf   = eff_buf;
        n_bits_held = eff_held;
        hdr_we      = 1'b0;
        hdr_idx     = eff_pos;
        n_res_valid = 1'b0;
        n_res.kind        = KIND_HEADER;
        n_res.line_number = hdr_line;
        n_res.did         = hdr_did;
        n_res.sdid        = hdr_sdid;
        n_res.data_count  = stored_dc;
        n_res.data_type   = hdr_type;
        n_res.data_word   = 8'd0;
        n_res.word_index  = 8'd0;
        n_res.last        = 1'b0;
        if (have_byte) begin
            case (eff_phase)
                PH_IDLE: ;
                PH_HUNT: begin
                    if (eff_left >= HUNT_MIN_LEFT && sync_hit) begin
                        hdr_we  = 1'b1;
                        hdr_idx = 3'd0;
                        n_pos   = 3'd1;
                    end
                end
                PH_HEAD: begin
                    hdr_we = 1'b1;
                    n_pos  = head_done ? 3'd0 : (eff_pos + 3'd1);
                    if (head_done && !too_long) begin
                        n_pkt_left       = need_bytes - HDR_BYTES;
                        n_word_cnt       = 8'd0;
                        n_bit_buf        = {12'd0, i_in.data_byte[3:0]};
                        n_bits_held      = FIRST_HELD;
                        n_res_valid      = 1'b1;
                        n_res.data_count = live_dc;
                        n_res.last       = (live_dc == 8'd0);
                    end
                end
                PH_BODY: begin
                    if (word_room) begin
                        n_bits_held = held_next;
                        n_bit_buf   = acc & 16'((17'd1 << held_next) - 17'd1);
                        if (emit) begin
                            n_word_cnt       = eff_wc + 8'd1;
                            n_res_valid      = 1'b1;
                            n_res.kind       = KIND_WORD;
                            n_res.data_word  = word_val;
                            n_res.word_index = eff_wc;
                            n_res.last       = ((eff_wc + 8'd1) == stored_dc);
                        end
                    end
                    n_pkt_left = pkt_dec;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pes_left  <= 16'd0;
            r_pos       <= 3'd0;
            r_pkt_left  <= 9'd0;
            r_word_cnt  <= 8'd0;
            r_bit_buf   <= 16'd0;
            r_bits_held <= 5'd0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_pes_left  <= n_pes_left;
            r_pos       <= n_pos;
            r_pkt_left  <= n_pkt_left;
            r_word_cnt  <= n_word_cnt;
            r_bit_buf   <= n_bit_buf;
            r_bits_held <= n_bits_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && hdr_we) begin
            r_hdr[hdr_idx] <= i_in.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && n_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_res_valid) begin
            r_out <= n_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out.kind;
    assign o_out.line_number = r_out.line_number;
    assign o_out.did         = r_out.did;
    assign o_out.sdid        = r_out.sdid;
    assign o_out.data_count  = r_out.data_count;
    assign o_out.data_type   = r_out.data_type;
    assign o_out.data_word   = r_out.data_word;
    assign o_out.word_index  = r_out.word_index;
    assign o_out.last        = r_out.last;

endmodule

// File: rtl/apd_checker.sv
// apd_checker: port-level assertions for the ancillary packet deframer,
// attached to the top level by the bind at the end of this file.
// Depends on apd_pkg.
module apd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_kind,
    input logic [7:0] i_data_count,
    input logic [7:0] i_data_word,
    input logic [7:0] i_word_index,
    input logic       i_last
);
    import apd_pkg::*;

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable({i_kind, i_data_count, i_data_word, i_word_index, i_last}))
        else $error("result payload changed while stalled");

    // input only stalls behind a waiting result
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    a_header_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_HEADER |->
            i_data_word == 8'd0 && i_word_index == 8'd0 &&
            i_last == (i_data_count == 8'd0))
        else $error("malformed header result");

    a_word_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_WORD |->
            i_word_index < i_data_count &&
            i_last == (({1'b0, i_word_index} + 9'd1) == {1'b0, i_data_count}))
        else $error("word result out of packet range");

endmodule

bind anc_packet_deframer apd_checker u_apd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_kind       (o_out.kind),
    .i_data_count (o_out.data_count),
    .i_data_word  (o_out.data_word),
    .i_word_index (o_out.word_index),
    .i_last       (o_out.last)
);

// File: verif/testbench.sv
// testbench: self-checking bench for anc_packet_deframer, built from random and
// hand-made PES payloads checked against a cycle-free predictor of the parser.
// Depends on apd_pkg, apd_stream_if.sv and the deframer RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import apd_pkg::*;

    typedef bit [7:0] pes_bytes_t [$];

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_BYTES = 540;

    localparam logic [15:0] KNOWN_KEYS [23] = '{
        16'h4105, 16'h4107, 16'h4108, 16'h410c, 16'h4302, 16'h4303, 16'h4501, 16'h4502,
        16'h4503, 16'h4504, 16'h4505, 16'h4506, 16'h4507, 16'h4508, 16'h4509, 16'h5fdc,
        16'h5fde, 16'h5fdf, 16'h5ffe, 16'h6060, 16'h6101, 16'h6102, 16'h6201
    };

    // tracks the parser state and the results each accepted byte should cause
    class anc_tracker;
        t_phase  phase;
        int      pes_left;
        int      hdr [8];
        int      hdr_pos;
        int      pkt_left;
        int      words_done;
        int      acc;
        int      acc_cnt;
        int      n_errors;
        t_result due_results [$];

        function new();
            phase      = PH_IDLE;
            pes_left   = 0;
            hdr_pos    = 0;
            pkt_left   = 0;
            words_done = 0;
            acc        = 0;
            acc_cnt    = 0;
            n_errors   = 0;
            foreach (hdr[i]) hdr[i] = 0;
        endfunction

        function int data_type_of(int did, int sdid);
            int code;
            code = TYPE_UNKNOWN;
            case (did)
                'h41: begin
                    case (sdid)
                        'h05: code = 3;
                        'h07: code = 5;
                        'h08: code = 13;
                        'h0c: code = 20;
                        default: ;
                    endcase
                end
                'h43: if (sdid == 'h02 || sdid == 'h03) code = 4;
                'h45: if (sdid >= 'h01 && sdid <= 'h09) code = 7;
                'h5f: begin
                    case (sdid)
                        'hdc, 'hde, 'hdf: code = 18;
                        'hfe: code = 17;
                        default: ;
                    endcase
                end
                'h60: if (sdid == 'h60) code = 6;
                'h61: begin
                    if (sdid == 'h01) code = 2;
                    else if (sdid == 'h02) code = 0;
                end
                'h62: if (sdid == 'h01) code = 15;
                default: ;
            endcase
            return code;
        endfunction

        // low 8 bits of the 10-bit data count
        function int word_total();
            return (((hdr[6] & 'h3F) << 4) | (hdr[7] >> 4)) & 'hFF;
        endfunction

        function t_result packet_fields();
            t_result r;
            int      did;
            int      sdid;
            r             = '0;
            did           = hdr[4];
            sdid          = ((hdr[5] << 2) | (hdr[6] >> 6)) & 'hFF;
            r.line_number = 11'(((hdr[0] & 1) << 10) | (hdr[1] << 2) | (hdr[2] >> 6));
            r.did         = 8'(did);
            r.sdid        = 8'(sdid);
            r.data_count  = 8'(word_total());
            r.data_type   = 5'(data_type_of(did, sdid));
            return r;
        endfunction

        function void take_byte(int b, bit first, int size);
            int      rem;
            int      dc;
            int      need;
            int      w;
            t_result r;
            if (first) begin
                phase      = PH_HUNT;
                pes_left   = size & 'hFFFF;
                hdr_pos    = 0;
                pkt_left   = 0;
                words_done = 0;
                acc        = 0;
                acc_cnt    = 0;
            end
            if (pes_left == 0) begin
                phase = PH_IDLE;
                return;
            end
            rem = pes_left;
            pes_left--;
            case (phase)
                PH_HUNT: begin
                    if (rem < 9) begin
                        phase = PH_IDLE;
                    end else if ((b & 'hFC) == 0) begin
                        hdr[0]  = b;
                        hdr_pos = 1;
                        phase   = PH_HEAD;
                    end
                end
                PH_HEAD: begin
                    hdr[hdr_pos & 7] = b;
                    hdr_pos = (hdr_pos + 1) & 'hF;
                    if (hdr_pos >= 8) begin
                        hdr_pos = 0;
                        dc      = word_total();
                        need    = (70 + 10 * dc + 7) / 8;
                        // packet longer than what is left of the PES
                        if (rem + 7 < need) begin
                            phase = PH_IDLE;
                        end else begin
                            pkt_left    = need - 8;
                            words_done  = 0;
                            acc         = b & 'hF;
                            acc_cnt     = 4;
                            phase       = PH_BODY;
                            r           = packet_fields();
                            r.kind      = KIND_HEADER;
                            r.last      = (dc == 0);
                            due_results.insert(due_results.size(), r);
                        end
                    end
                end
                PH_BODY: begin
                    dc = word_total();
                    if (words_done < dc) begin
                        acc     = ((acc << 8) | b) & 'hFFFF;
                        acc_cnt = acc_cnt + 8;
                        if (acc_cnt >= 10) begin
                            w            = (acc >> (acc_cnt - 10)) & 'hFF;
                            acc_cnt      = acc_cnt - 10;
                            acc          = acc & ((1 << acc_cnt) - 1);
                            r            = packet_fields();
                            r.kind       = KIND_WORD;
                            r.data_word  = 8'(w);
                            r.word_index = 8'(words_done);
                            words_done++;
                            r.last       = (words_done == dc);
                            due_results.insert(due_results.size(), r);
                        end
                    end
                    if (pkt_left > 0) pkt_left--;
                    if (pkt_left == 0) phase = PH_HUNT;
                end
                default: ;
            endcase
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                n_errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                $error("result with nothing expected: kind %0d line %0d index %0d",
                       got.kind, got.line_number, got.word_index);
                n_errors++;
                return;
            end
            want = due_results.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("line_number", want.line_number, got.line_number);
            check_field("did", want.did, got.did);
            check_field("sdid", want.sdid, got.sdid);
            check_field("data_count", want.data_count, got.data_count);
            check_field("data_type", want.data_type, got.data_type);
            check_field("data_word", want.data_word, got.data_word);
            check_field("word_index", want.word_index, got.word_index);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    apd_in_if  in_ch ();
    apd_out_if out_ch ();

    anc_packet_deframer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    anc_tracker tracker;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         bytes_done    = 0;
    int         quiet_cycles  = 0;
    logic       rx_stall_go;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random back-pressure, plus one long hold-off when asked
    initial begin : rx_side
        int hold_left;
        bit stall_taken;
        hold_left   = 0;
        stall_taken = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_stall_go === 1'b1 && !stall_taken) begin
                stall_taken = 1;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : monitor_blk
        t_result seen;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                tracker.take_byte(int'(in_ch.data_byte), in_ch.pes_start, int'(in_ch.pes_size));
            end
            if (out_ch.valid && out_ch.ready) begin
                seen.kind        = out_ch.kind;
                seen.line_number = out_ch.line_number;
                seen.did         = out_ch.did;
                seen.sdid        = out_ch.sdid;
                seen.data_count  = out_ch.data_count;
                seen.data_type   = out_ch.data_type;
                seen.data_word   = out_ch.data_word;
                seen.word_index  = out_ch.word_index;
                seen.last        = out_ch.last;
                tracker.check_result(seen);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    function automatic void push_bits(ref bit bq [$], input int v, input int n);
        for (int i = n - 1; i >= 0; i--) bq.insert(bq.size(), v[i]);
    endfunction

    // one ancillary packet, fill < 0 gives random user words
    function automatic void add_packet(ref pes_bytes_t q, input int line, input int did8,
                                       input int sdid8, input int dc8, input int fill);
        bit bq [$];
        int v;
        push_bits(bq, 0, 6);
        push_bits(bq, $urandom_range(1), 1);
        push_bits(bq, line, 11);
        push_bits(bq, $urandom_range(4095), 12);
        // top two bits of each 10-bit field are random, the parser drops them
        push_bits(bq, ($urandom_range(3) << 8) | did8, 10);
        push_bits(bq, ($urandom_range(3) << 8) | sdid8, 10);
        push_bits(bq, ($urandom_range(3) << 8) | dc8, 10);
        for (int i = 0; i < dc8; i++) push_bits(bq, (fill < 0) ? $urandom_range(1023) : fill, 10);
        push_bits(bq, $urandom_range(1023), 10);
        while (bq.size() % 8 != 0) bq.insert(bq.size(), 1'($urandom_range(1)));
        for (int i = 0; i < bq.size(); i += 8) begin
            v = 0;
            for (int j = 0; j < 8; j++) v = (v << 1) | bq[i + j];
            q.insert(q.size(), v[7:0]);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first, input logic [15:0] size);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.pes_start <= first;
        in_ch.pes_size  <= size;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_pes(input pes_bytes_t q, input int size);
        foreach (q[i]) begin
            send_byte(q[i], i == 0, (i == 0) ? 16'(size) : 16'($urandom_range(65535)));
        end
        bytes_done += (size < q.size()) ? size : q.size();
    endtask

    // stop offering requests until every expected result has come out
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int budget, input bit with_big);
        pes_bytes_t q;
        int         start_count;
        int         size;
        int         len;
        int         npk;
        int         key;
        int         dc;
        int         r;
        bit         big_here;
        start_count = bytes_done;
        while (bytes_done - start_count < budget) begin
            q.delete();
            big_here = 0;
            r = $urandom_range(99);
            if (r < 10) begin
                // plain noise
                len = $urandom_range(1, 16);
                for (int i = 0; i < len; i++) q.insert(q.size(), 8'($urandom_range(255)));
                size = $urandom_range(1) ? len : $urandom_range(65535);
            end else begin
                repeat ($urandom_range(2)) q.insert(q.size(), 8'($urandom_range(255)));
                npk = $urandom_range(1, 3);
                for (int i = 0; i < npk; i++) begin
                    if (with_big) begin
                        dc       = 255;
                        with_big = 0;
                        big_here = 1;
                    end else begin
                        r = $urandom_range(99);
                        if (r < 85) dc = $urandom_range(0, 6);
                        else if (r < 98) dc = $urandom_range(7, 40);
                        else dc = $urandom_range(41, 120);
                    end
                    if ($urandom_range(99) < 60) key = KNOWN_KEYS[$urandom_range(22)];
                    else key = $urandom_range(65535);
                    add_packet(q, $urandom_range(2047), key >> 8, key & 'hFF, dc, -1);
                    repeat ($urandom_range(2)) q.insert(q.size(), 8'hFF);
                end
                len = q.size();
                r   = big_here ? 0 : $urandom_range(99);
                if (r < 70) begin
                    size = len;
                end else if (r < 78) begin
                    // next start arrives early
                    size = len + $urandom_range(1, 6);
                end else if (r < 88) begin
                    // payload cut short, tail bytes fall past the end
                    size = len - $urandom_range(1, (len - 1 > 10) ? 10 : len - 1);
                end else if (r < 92) begin
                    size = 0;
                end else if (r < 96) begin
                    size = $urandom_range(65535);
                end else begin
                    size = len;
                    r    = $urandom_range(1, len - 1);
                    while (q.size() > r) void'(q.pop_back());
                end
            end
            send_pes(q, size);
        end
    endtask

    initial begin : main_seq
        pes_bytes_t q;
        tracker = new();
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'd0;
        in_ch.pes_start <= 1'b0;
        in_ch.pes_size  <= 16'd0;
        rx_stall_go     <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // shortest packet, no user words, top line number
        add_packet(q, 2047, 'h61, 'h01, 0, -1);
        send_pes(q, q.size());
        // zero-length pes
        q.delete();
        q.insert(q.size(), 8'h00);
        send_pes(q, 0);
        // one word of all ones, unknown type, line zero
        q.delete();
        add_packet(q, 0, 'hFF, 'hFF, 1, 'h3FF);
        send_pes(q, q.size());
        // a one-word packet one byte short of its length
        q.delete();
        add_packet(q, 1024, 'h00, 'h00, 1, 0);
        send_pes(q, q.size() - 1);
        drain();

        send_idle_pct = 18;
        recv_idle_pct = 75;
        run_random(PHASE_BYTES, 1'b0);
        drain();

        send_idle_pct = 75;
        recv_idle_pct = 18;
        run_random(PHASE_BYTES, 1'b0);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        rx_stall_go <= 1'b1;
        run_random(PHASE_BYTES, 1'b1);
        drain();

        repeat (16) @(posedge i_clk);
        if (tracker.n_errors == 0 && tracker.due_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (tracker.due_results.size() != 0) begin
                $error("%0d expected results never came", tracker.due_results.size());
            end
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
